// ===== rtl/brm_pkg.sv =====
// brm_pkg: field widths shared by the Booth multiplier and its channel interfaces
// no dependencies
package brm_pkg;

	localparam int unsigned OPERAND_W = 16;
	localparam int unsigned PRODUCT_W = 32;

	typedef logic signed [OPERAND_W-1:0] operand_t;
	typedef logic signed [PRODUCT_W-1:0] product_t;

endpackage

// ===== rtl/brm_if.sv =====
// brm_if: valid/ready channel interfaces for operand and product transactions
// depends on brm_pkg
interface brm_operand_if import brm_pkg::*; ();
	logic     valid;
	logic     ready;
	operand_t multiplicand;
	operand_t multiplier;

	modport source (output valid, output multiplicand, output multiplier, input ready);
	modport sink (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface brm_product_if import brm_pkg::*; ();
	logic     valid;
	logic     ready;
	product_t product;

	modport source (output valid, output product, input ready);
	modport sink (input valid, input product, output ready);
endinterface

// ===== rtl/booth_radix2_multiplier.sv =====
// booth_radix2_multiplier: pipelined radix-2 Booth signed multiplier, one recoding step per stage
// depends on brm_pkg, brm_operand_if and brm_product_if
//
// Usage:
//   operands (sink): one transaction carries a signed multiplicand and multiplier,
//   taken at a clock edge where valid and ready are both high.
//   result (source): one transaction per operand pair, in order, carrying the signed
//   product; the operands are sign-extended or cut to WIDTH bits, the 2*WIDTH-bit
//   product is sign-extended or cut to 32 bits.
//   Stages: an input register, then WIDTH Booth stages (at most one add or subtract each);
//   a product is offered once its operands have passed the input register and every Booth stage.
//   Throughput: one transaction per cycle while the receiver does not stall, set by the per-stage adder.
//   Reset (arst_n low) empties every stage at once; nothing is offered until new
//   operands arrive.
//   When the receiver stalls, the product holds in the last stage; each stage takes
//   a new item whenever it is empty or the stage after it moves, so bubbles close
//   up and operands keep being taken until the whole pipeline is full.
module booth_radix2_multiplier
	import brm_pkg::*;
#(
	parameter int unsigned WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	brm_operand_if.sink          operands,
	brm_product_if.source        result
);

	localparam int unsigned PW = 2 * WIDTH;

	logic             valid_s [0:WIDTH];
	logic             rdy     [0:WIDTH];
	logic [WIDTH-1:0] a_s     [0:WIDTH];
	logic [WIDTH-1:0] q_s     [0:WIDTH];
	logic [WIDTH-1:0] m_s     [0:WIDTH];
	logic             e_s     [0:WIDTH];

	logic [WIDTH-1:0] m_in;
	logic [WIDTH-1:0] q_in;
	logic [PW-1:0]    prod_full;

	// operand resize
	generate
		if (WIDTH <= OPERAND_W) begin : g_cut
			assign m_in = operands.multiplicand[WIDTH-1:0];
			assign q_in = operands.multiplier[WIDTH-1:0];
		end else begin : g_ext
			assign m_in = {{(WIDTH-OPERAND_W){operands.multiplicand[OPERAND_W-1]}},
				operands.multiplicand};
			assign q_in = {{(WIDTH-OPERAND_W){operands.multiplier[OPERAND_W-1]}},
				operands.multiplier};
		end
	endgenerate

	// ready chain from the output back
	assign rdy[WIDTH] = !valid_s[WIDTH] || result.ready;
	generate
		for (genvar k = 0; k < WIDTH; k++) begin : g_rdy
			assign rdy[k] = !valid_s[k] || rdy[k+1];
		end
	endgenerate

	assign operands.ready = rdy[0];

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			valid_s[0] <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && operands.valid) begin
			a_s[0] <= '0;
			q_s[0] <= q_in;
			m_s[0] <= m_in;
			e_s[0] <= 1'b0;
		end
	end

	// booth stages
	generate
		for (genvar k = 1; k <= WIDTH; k++) begin : g_step
			logic [WIDTH-1:0] sum;

			always_comb begin
				case ({q_s[k-1][0], e_s[k-1]})
					2'b01:   sum = a_s[k-1] + m_s[k-1];
					2'b10:   sum = a_s[k-1] - m_s[k-1];
					default: sum = a_s[k-1];
				endcase
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && valid_s[k-1]) begin
					e_s[k] <= q_s[k-1][0];
					q_s[k] <= {sum[0], q_s[k-1][WIDTH-1:1]};
					a_s[k] <= {sum[WIDTH-1], sum[WIDTH-1:1]};
					m_s[k] <= m_s[k-1];
				end
			end
		end
	endgenerate

	// product resize
	assign prod_full = {a_s[WIDTH], q_s[WIDTH]};

	generate
		if (PW >= PRODUCT_W) begin : g_pcut
			assign result.product = prod_full[PRODUCT_W-1:0];
		end else begin : g_pext
			assign result.product = {{(PRODUCT_W-PW){prod_full[PW-1]}}, prod_full};
		end
	endgenerate

	assign result.valid = valid_s[WIDTH];

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!operands.ready |-> result.valid && !result.ready)
		else $error("operands refused while the output is free");

	a_first_step_extra_bit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] && rdy[1] |=> valid_s[1] && (e_s[1] == $past(q_s[0][0])))
		else $error("first booth stage lost the multiplier lsb");

	a_zero_multiplicand: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (m_s[WIDTH] == '0) |-> result.product == '0)
		else $error("zero multiplicand gave a non-zero product");
`endif

endmodule

// ===== verif/booth_radix2_multiplier_tb.sv =====
`timescale 1ns / 1ps
// booth_radix2_multiplier_tb: self-checking bench for the Booth multiplier, corner operands,
// recoding patterns, output hold-off and random pairs against a bit-level Booth predictor
// depends on brm_pkg, brm_operand_if, brm_product_if and booth_radix2_multiplier
module booth_radix2_multiplier_tb;
	import brm_pkg::*;

	localparam int unsigned WIDTH = 16;
	localparam int unsigned RANDOM_PAIRS = 1500;
	localparam int unsigned PHASE_PAIRS = 150;
	localparam int unsigned CALM_PAIRS = 300;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned PRESSURE_PAIRS = 45;
	localparam int unsigned DRAIN_LIMIT = 2000;
	localparam int unsigned SHOWN_ERRORS = 10;
	localparam longint TIMEOUT_NS = 2_000_000;
	localparam logic [1:0] BOOTH_ADD = 2'b01;
	localparam logic [1:0] BOOTH_SUB = 2'b10;

	logic clk;
	logic arst_n;

	brm_operand_if opnd ();
	brm_product_if prod ();

	booth_radix2_multiplier #(
		.WIDTH(WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.operands(opnd),
		.result(prod)
	);

	product_t    expected_products[$];
	int unsigned pairs_sent;
	int unsigned directed_pairs;
	int unsigned products_checked;
	int unsigned product_errors;
	int unsigned input_stall_cycles;
	bit          tx_gaps_on;
	bit          rx_stalls_on;
	bit          hold_req;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("booth_radix2_multiplier: mismatch");
		$finish;
	end

	function automatic product_t booth_product(operand_t mcand, operand_t mplier);
		logic signed [63:0]        wide_m;
		logic signed [63:0]        wide_q;
		logic [WIDTH-1:0]          m;
		logic [WIDTH-1:0]          q;
		logic [WIDTH-1:0]          acc;
		logic                      e;
		logic signed [2*WIDTH-1:0] full;
		logic signed [63:0]        wide_p;
		wide_m = mcand;
		wide_q = mplier;
		m = wide_m[WIDTH-1:0];
		q = wide_q[WIDTH-1:0];
		acc = '0;
		e = 1'b0;
		for (int i = 0; i < WIDTH; i++) begin
			case ({q[0], e})
				BOOTH_ADD: acc = acc + m;
				BOOTH_SUB: acc = acc - m;
				default: ;
			endcase
			e = q[0];
			q = {acc[0], q[WIDTH-1:1]};
			acc = {acc[WIDTH-1], acc[WIDTH-1:1]};
		end
		full = {acc, q};
		wide_p = full;
		return wide_p[PRODUCT_W-1:0];
	endfunction

	function automatic operand_t random_operand();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind < 7)
			return operand_t'($urandom);
		else if (kind == 7)
			return operand_t'($urandom_range(0, 16) - 8);
		else if (kind == 8)
			return $urandom_range(0, 1) ? operand_t'(16'h8000 + $urandom_range(0, 3))
				: operand_t'(16'h7FFF - $urandom_range(0, 3));
		else
			return operand_t'(16'h1 << $urandom_range(0, 15));
	endfunction

	task automatic report_error(string what, product_t want, product_t got);
		product_errors++;
		if (product_errors <= SHOWN_ERRORS)
			$display("product error (%s) at %0t: expected %0d (%h), got %0d (%h)",
				what, $realtime, want, want, got, got);
	endtask

	// one operand transaction, with an optional idle burst ahead of it
	task automatic send_operands(operand_t mcand, operand_t mplier);
		int unsigned gap;
		gap = 0;
		if (tx_gaps_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			@(negedge clk);
			opnd.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		opnd.valid <= 1'b1;
		opnd.multiplicand <= mcand;
		opnd.multiplier <= mplier;
		do
			@(posedge clk);
		while (opnd.ready !== 1'b1);
		expected_products.push_back(booth_product(mcand, mplier));
		pairs_sent++;
	endtask

	always @(posedge clk) begin : product_check
		product_t want;
		if (arst_n && opnd.valid && opnd.ready !== 1'b1)
			input_stall_cycles++;
		if (arst_n && prod.valid === 1'b1 && prod.ready) begin
			if (expected_products.size() == 0) begin
				report_error("unexpected", '0, prod.product);
			end else begin
				want = expected_products.pop_front();
				products_checked++;
				if (prod.product !== want)
					report_error("value", want, prod.product);
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int unsigned hold_left;
		int unsigned stall_left;
		hold_left = 0;
		stall_left = 0;
		prod.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				prod.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				prod.ready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				prod.ready <= 1'b0;
			end else begin
				prod.ready <= 1'b1;
			end
		end
	end

	task automatic test_corner_operands();
		operand_t corners[6];
		corners = '{16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF};
		for (int i = 0; i < 6; i++) begin
			send_operands(corners[i], corners[i]);
			send_operands(corners[i], corners[5-i]);
		end
	endtask

	// alternating and run patterns to hit every recoding pair in long runs
	task automatic test_recoding_patterns();
		send_operands(16'sh5555, 16'sh5555);
		send_operands(16'shAAAA, 16'sh5555);
		send_operands(16'sh7FFF, 16'shAAAA);
		send_operands(16'sh8000, 16'sh00FF);
		send_operands(16'sh00FF, 16'shFF00);
		send_operands(16'sh8001, 16'sh8001);
		send_operands(16'sh1234, 16'shEDCC);
		send_operands(16'shFFFF, 16'sh7FFF);
		directed_pairs = pairs_sent;
	endtask

	task automatic test_output_holdoff();
		hold_req = 1'b1;
		for (int i = 0; i < PRESSURE_PAIRS; i++)
			send_operands(random_operand(), random_operand());
	endtask

	task automatic test_random_operands();
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			if (i % PHASE_PAIRS == 0) begin
				tx_gaps_on = ((i / PHASE_PAIRS) % 4) inside {0, 1};
				rx_stalls_on = ((i / PHASE_PAIRS) % 4) inside {0, 2};
				if (i >= RANDOM_PAIRS - CALM_PAIRS) begin
					tx_gaps_on = 1'b0;
					rx_stalls_on = 1'b0;
				end
			end
			send_operands(random_operand(), random_operand());
		end
	endtask

	initial begin : run
		int unsigned waited;
		arst_n = 1'b0;
		opnd.valid = 1'b0;
		opnd.multiplicand = '0;
		opnd.multiplier = '0;
		pairs_sent = 0;
		directed_pairs = 0;
		products_checked = 0;
		product_errors = 0;
		input_stall_cycles = 0;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		hold_req = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_corner_operands();
		test_recoding_patterns();
		test_output_holdoff();
		test_random_operands();

		@(negedge clk);
		opnd.valid <= 1'b0;
		waited = 0;
		while (expected_products.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (WIDTH + 8) @(posedge clk);
		while (expected_products.size() != 0)
			report_error("missing", expected_products.pop_front(), '0);

		$display("%0d operand transactions (%0d directed), %0d products checked, %0d errors",
			pairs_sent, directed_pairs, products_checked, product_errors);
		$display("input held back for %0d cycles, including a %0d-cycle output hold-off",
			input_stall_cycles, HOLD_CYCLES);
		if (product_errors == 0)
			$display("booth_radix2_multiplier: match");
		else
			$display("booth_radix2_multiplier: mismatch");
		$finish;
	end

endmodule
